// ===== hdl/ufmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufmc_pkg - shared constants and helpers for the maze carver
// Grid limits, field widths, register indexes and the small neighbour-pick
// reduction used by the sequencer.
// ----------------------------------------------------------------------------
package ufmc_pkg;

  // MAX_SIDE * MAX_SIDE must not exceed MAX_CELLS, so a clamped grid always fits
  localparam int MAX_CELLS = 1024;
  localparam int MAX_SIDE  = 32;

  localparam int CELL_W  = $clog2(MAX_CELLS);
  localparam int COUNT_W = CELL_W + 1;
  localparam int SIDE_W  = 6;
  localparam int PICK_W  = 8;
  localparam int IDX_W   = 2;
  localparam int STEP_W  = $clog2(CELL_W);

  localparam logic [SIDE_W-1:0] ROW_RESET = SIDE_W'(8);
  localparam logic [SIDE_W-1:0] COL_RESET = SIDE_W'(8);
  localparam logic [SIDE_W-1:0] SIDE_MIN  = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX  = SIDE_W'(MAX_SIDE);

  localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(1);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] s;
    s = v;
    if (s < SIDE_MIN) s = SIDE_MIN;
    if (s > SIDE_MAX) s = SIDE_MAX;
    return s;
  endfunction

  // pick modulo a neighbour count of 2, 3 or 4; mod 3 via base-4 digit sums
  function automatic logic [1:0] pick_mod(input logic [PICK_W-1:0] p,
                                          input logic [2:0] cnt);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] s3;
    logic [1:0] m3;
    s1 = {2'b00, p[1:0]} + {2'b00, p[3:2]} + {2'b00, p[5:4]} + {2'b00, p[7:6]};
    s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
    s3 = s2[2] ? (s2[1:0] + 2'd1) : s2[1:0];
    m3 = (s3 == 2'd3) ? 2'd0 : s3;
    case (cnt)
      3'd2:    return {1'b0, p[0]};
      3'd3:    return m3;
      default: return p[1:0];
    endcase
  endfunction

endpackage

// ===== hdl/ufmc_ram.sv =====
// ----------------------------------------------------------------------------
// ufmc_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ufmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/ufmc_rem.sv =====
// ----------------------------------------------------------------------------
// ufmc_rem - iterative remainder unit
// Restoring division, one dividend bit per cycle; yields cell mod columns.
// ----------------------------------------------------------------------------
module ufmc_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ufmc_pkg::CELL_W-1:0] dividend,
  input  logic [ufmc_pkg::SIDE_W-1:0] divisor,
  output logic [ufmc_pkg::SIDE_W-1:0] rem,
  output logic                        done
);
  import ufmc_pkg::*;

  logic [CELL_W-1:0] num;
  logic [SIDE_W-1:0] den;
  logic [STEP_W-1:0] step;
  logic              busy;

  logic [SIDE_W:0]   trial;
  logic [SIDE_W:0]   diff;
  logic [SIDE_W-1:0] rem_next;

  // remainder stays below the divisor, so it always fits SIDE_W bits
  always_comb begin
    trial    = {rem, num[step]};
    diff     = trial - {1'b0, den};
    rem_next = (trial >= {1'b0, den}) ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        step <= STEP_W'(CELL_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/union_find_maze_carver_unit.sv =====
// ----------------------------------------------------------------------------
// union_find_maze_carver_unit - Kruskal maze carver over disjoint sets
// Sequencer, size registers, set store and result register.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_index 0 writes the row count, 1 the column count
//                  (clamped to 2..MAX_SIDE); other indexes are ignored. Any
//                  size write starts a clearing pass over the set store.
//   in channel   : one request per cell_req / pick pair; in_ready is high
//                  only while the sequencer is idle.
//   out channel  : one result per request, held in an output register.
// Timing: in_ready stays low from acceptance until the result is loaded, so
//   requests do not overlap; the time per request grows with da and db, the
//   parent-chain depths of the two cells. The 10-step remainder unit (cell
//   mod columns) and the single read port of the set store set the pace.
//   Bad-cell and already-complete requests skip the remainder unit and the
//   store walk and go straight from idle to the output load.
// Reset: sizes go to 8 x 8, then a clearing pass over all MAX_CELLS (1024)
//   entries points every store entry at itself; in_ready stays low meanwhile.
// Stall: a new request is taken while a result waits; a second result holds
//   the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module union_find_maze_carver_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ufmc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ufmc_pkg::SIDE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ufmc_pkg::CELL_W-1:0]  cell_req,
  input  logic [ufmc_pkg::PICK_W-1:0]  pick,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         joined,
  output logic [ufmc_pkg::CELL_W-1:0]  low_cell,
  output logic [ufmc_pkg::CELL_W-1:0]  high_cell,
  output logic [ufmc_pkg::COUNT_W-1:0] sets_left,
  output logic                         complete,
  output logic                         bad_cell
);
  import ufmc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_FIND, S_COMP, S_JOIN, S_LOAD
  } state_t;

  state_t             state;
  logic [CELL_W-1:0]  clr_cnt;
  logic [SIDE_W-1:0]  rows;
  logic [SIDE_W-1:0]  cols;
  logic [COUNT_W-1:0] cells;
  logic [COUNT_W-1:0] bottom;
  logic [COUNT_W-1:0] set_total;
  logic [CELL_W-1:0]  cell_q;
  logic [PICK_W-1:0]  pick_q;
  logic [CELL_W-1:0]  other;
  logic [CELL_W-1:0]  cur;
  logic [CELL_W-1:0]  root;
  logic [CELL_W-1:0]  node;
  logic [CELL_W-1:0]  ra;
  logic               second;
  logic               res_joined;
  logic [CELL_W-1:0]  res_lo;
  logic [CELL_W-1:0]  res_hi;
  logic               res_bad;

  logic [COUNT_W-1:0] cell_x;
  logic [COUNT_W-1:0] cols_x;
  logic [COUNT_W-1:0] nb_h0, nb_h1, nb_v0, nb_v1, nb_sel;
  logic               left_ok, right_ok, up_ok, down_ok;
  logic               h_two, v_two;
  logic [2:0]         nb_cnt;
  logic [1:0]         nb_idx;
  logic [CELL_W-1:0]  start_node;
  logic               hit;
  logic               comp_end;
  logic               bad_in;
  logic               early;
  logic               accept;
  logic               load_fire;
  logic               size_wr;
  logic               rem_start;
  logic [SIDE_W-1:0]  rem;
  logic               rem_done;

  logic               ram_wr_en;
  logic [CELL_W-1:0]  ram_wr_addr;
  logic [CELL_W-1:0]  ram_wr_data;
  logic [CELL_W-1:0]  ram_rd_addr;
  logic [CELL_W-1:0]  ram_rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign bad_in    = (COUNT_W'(cell_req) >= cells);
  assign early     = bad_in || (set_total == COUNT_W'(1));
  assign rem_start = accept && !early;
  assign load_fire = (state == S_LOAD) && (!out_valid || out_ready);
  assign size_wr   = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

  // neighbour list: horizontal first (left, right), then vertical (up, down)
  always_comb begin
    cell_x   = COUNT_W'(cell_q);
    cols_x   = COUNT_W'(cols);
    left_ok  = (rem != '0);
    right_ok = (rem != (cols - 1'b1));
    up_ok    = (cell_x >= cols_x);
    down_ok  = (cell_x < bottom);
    nb_h0    = left_ok ? (cell_x - 1'b1) : (cell_x + 1'b1);
    nb_h1    = cell_x + 1'b1;
    nb_v0    = up_ok ? (cell_x - cols_x) : (cell_x + cols_x);
    nb_v1    = cell_x + cols_x;
    h_two    = left_ok && right_ok;
    v_two    = up_ok && down_ok;
    nb_cnt   = 3'd2 + {2'b00, h_two} + {2'b00, v_two};
    nb_idx   = pick_mod(pick_q, nb_cnt);
    if (nb_idx == 2'd0) begin
      nb_sel = nb_h0;
    end else if (nb_idx == 2'd1 && h_two) begin
      nb_sel = nb_h1;
    end else if ((nb_idx == 2'd1 && !h_two) || (nb_idx == 2'd2 && h_two)) begin
      nb_sel = nb_v0;
    end else begin
      nb_sel = nb_v1;
    end
  end

  assign start_node = second ? other : cell_q;
  assign hit        = (ram_rd_data == cur);
  assign comp_end   = (ram_rd_data == root);

  // store ports: read data of the address issued last cycle arrives now
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_cnt;
    ram_wr_data = clr_cnt;
    ram_rd_addr = cur;
    case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_DIV: begin
        ram_rd_addr = cell_q;
      end
      S_FIND: begin
        if (!hit) begin
          ram_rd_addr = ram_rd_data;
        end else if (start_node != cur) begin
          ram_rd_addr = start_node;
        end else begin
          ram_rd_addr = other;
        end
      end
      S_COMP: begin
        if (comp_end) begin
          ram_rd_addr = other;
        end else begin
          ram_rd_addr = ram_rd_data;
          ram_wr_en   = 1'b1;
          ram_wr_addr = node;
          ram_wr_data = root;
        end
      end
      S_JOIN: begin
        ram_wr_en   = (ra != root);
        ram_wr_addr = ra;
        ram_wr_data = root;
      end
      default: begin
        ram_rd_addr = cur;
      end
    endcase
  end

  ufmc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ufmc_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cell_req),
    .divisor  (cols),
    .rem      (rem),
    .done     (rem_done)
  );

  // grid size products are registered and follow the size registers in the next cycle
  always_ff @(posedge clk) begin
    cells  <= COUNT_W'(rows) * COUNT_W'(cols);
    bottom <= COUNT_W'(rows - 1'b1) * COUNT_W'(cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rows      <= ROW_RESET;
      cols      <= COL_RESET;
      set_total <= COUNT_W'(ROW_RESET) * COUNT_W'(COL_RESET);
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // size write: new grid, restart the clearing pass
      if (size_wr) begin
        if (cfg_index == REG_ROWS) begin
          rows <= clamp_side(cfg_data);
        end else begin
          cols <= clamp_side(cfg_data);
        end
        clr_cnt <= '0;
        state   <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == CELL_W'(MAX_CELLS - 1)) begin
              set_total <= cells;
              state     <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              cell_q     <= cell_req;
              pick_q     <= pick;
              second     <= 1'b0;
              res_joined <= 1'b0;
              res_lo     <= '0;
              res_hi     <= '0;
              res_bad    <= bad_in;
              state      <= early ? S_LOAD : S_DIV;
            end
          end
          S_DIV: begin
            if (rem_done) begin
              other <= nb_sel[CELL_W-1:0];
              cur   <= cell_q;
              state <= S_FIND;
            end
          end
          S_FIND: begin
            if (!hit) begin
              cur <= ram_rd_data;
            end else begin
              root <= cur;
              if (start_node != cur) begin
                node  <= start_node;
                state <= S_COMP;
              end else if (!second) begin
                ra     <= cur;
                second <= 1'b1;
                cur    <= other;
              end else begin
                state <= S_JOIN;
              end
            end
          end
          S_COMP: begin
            if (!comp_end) begin
              node <= ram_rd_data;
            end else if (!second) begin
              ra     <= root;
              second <= 1'b1;
              cur    <= other;
              state  <= S_FIND;
            end else begin
              state <= S_JOIN;
            end
          end
          S_JOIN: begin
            if (ra != root) begin
              set_total  <= set_total - 1'b1;
              res_joined <= 1'b1;
              res_lo     <= (cell_q < other) ? cell_q : other;
              res_hi     <= (cell_q < other) ? other : cell_q;
            end
            state <= S_LOAD;
          end
          S_LOAD: begin
            if (load_fire) begin
              joined    <= res_joined;
              low_cell  <= res_lo;
              high_cell <= res_hi;
              sets_left <= set_total;
              complete  <= (set_total == COUNT_W'(1));
              bad_cell  <= res_bad;
              state     <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  a_join_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && joined |-> (low_cell < high_cell))
    else $error("removed wall not reported low then high");

  a_join_adjacent: assert property (@(posedge clk) disable iff (rst)
    out_valid && joined |->
      ((COUNT_W'(high_cell) - COUNT_W'(low_cell)) == COUNT_W'(1)) ||
      ((COUNT_W'(high_cell) - COUNT_W'(low_cell)) == COUNT_W'(cols)))
    else $error("removed wall joins cells that are not neighbours");

  a_complete_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (complete == (sets_left == COUNT_W'(1))))
    else $error("complete flag disagrees with set count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != S_CLEAR) |->
      ((set_total == $past(set_total)) || (set_total == ($past(set_total) - 1'b1))))
    else $error("set count moved by more than one merge");

endmodule
